// ----- rtl/bcc_pkg.sv -----
package bcc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    // Input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Pixel levels
    localparam logic [7:0] PIX_ON  = 8'd255;
    localparam logic [7:0] PIX_OFF = 8'd0;

    // Line store word: {dilated parity1, dilated parity0, input parity1, input parity0}
    localparam int   WORD_W   = 4;
    localparam logic IN_SLOT  = 1'b0;
    localparam logic DIL_SLOT = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // Classification of one raster step, handed from front to back
    typedef struct packed {
        logic parity;      // row parity of the step
        logic row_ge1;     // a row above exists: dilate it
        logic row_ge2;     // two rows above: emit a result
        logic row_ge3;     // three rows above: dilated row above the result is real
        logic below_out;   // row below the result lies outside the frame
        logic first_col;
        logic last_col;
        logic fg;          // foreground bit of the entering pixel
        logic frame_last;
    } step_flags_t;

endpackage

// ----- rtl/binary_closing_cross.sv -----
// Streaming binary closing (dilation then erosion, 4-neighbour cross) of an 8-bit image
// in raster order; a pixel is foreground only at 255, results are 0 or 255 and neighbours
// outside the frame are ignored. Sustained rate is one beat per clock on both channels
// while out_ready stays high: the back end reads one line-RAM word at the current and at
// the next column and writes one word back per pixel, so nothing is iterated. The result
// for row r leaves once the pixel of row r+2 at the same column has been taken, so at
// frame end 2*W flush beats (W for a one-row frame) drain the last two rows; frame_last
// marks the final result. A flush beat before the frame is complete is taken and dropped;
// a pixel beat after the frame is complete acts as a flush. For a one-row frame, in_ready
// drops after the last pixel while the dilated row is built. An accepted beat reaches its
// result through the queue, the RAM read and the output register. Writing image_width or
// image_height (clamped to 1..MAX) restarts the frame; the line RAM needs no clearing pass
// since stale entries are masked by the row position.
module binary_closing_cross #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [7:0]                      pixel_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      closed_pixel,
    output logic                            frame_last
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int FW  = $bits(bcc_pkg::step_flags_t);
    localparam int QW  = AW + FW;

    logic                 push_valid;
    logic                 push_ready;
    logic [AW-1:0]        push_col;
    bcc_pkg::step_flags_t push_flags;

    logic                 q_valid;
    logic                 q_ready;
    logic [QW-1:0]        q_data;
    logic [AW-1:0]        q_col;
    bcc_pkg::step_flags_t q_flags;

    // Classify each beat into a raster step, or drop it
    bcc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .pixel_value (pixel_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_col    (push_col),
        .push_flags  (push_flags)
    );

    // Hold steps so the front keeps taking beats while the back stalls
    bcc_queue #(
        .WIDTH (QW),
        .DEPTH (bcc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_col, push_flags}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_col   = q_data[QW-1:FW];
    assign q_flags = bcc_pkg::step_flags_t'(q_data[FW-1:0]);

    // Dilate, erode and advance the line store
    bcc_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_col        (q_col),
        .q_flags      (q_flags),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .closed_pixel (closed_pixel),
        .frame_last   (frame_last)
    );

endmodule

// ----- rtl/bcc_ram.sv -----
module bcc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- rtl/bcc_queue.sv -----
module bcc_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
        next_ptr = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/bcc_front.sv -----
module bcc_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [7:0]                       pixel_value,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]     push_col,
    output bcc_pkg::step_flags_t             push_flags
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    localparam logic [WW-1:0] W_RESET = (bcc_pkg::WIDTH_RESET > MAX_WIDTH) ?
        WW'(MAX_WIDTH) : WW'(bcc_pkg::WIDTH_RESET);
    localparam logic [HW-1:0] H_RESET = (bcc_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
        HW'(MAX_HEIGHT) : HW'(bcc_pkg::HEIGHT_RESET);

    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [RW-1:0] vrow_reg;
    logic [AW-1:0] vcol_reg;

    logic          cfg_fire;
    logic          push_fire;
    logic [RW-1:0] h_ext;
    logic [RW-1:0] h_plus1;
    logic          real_row;
    logic          silent;
    logic          in_fire;
    logic          last_col;
    logic          frame_end;

    function automatic logic [WW-1:0] clamp_w(input logic [bcc_pkg::CFG_DATA_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == '0)
            clamp_w = WW'(1);
        else if (v32 > 32'(MAX_WIDTH))
            clamp_w = WW'(MAX_WIDTH);
        else
            clamp_w = WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [bcc_pkg::CFG_DATA_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == '0)
            clamp_h = HW'(1);
        else if (v32 > 32'(MAX_HEIGHT))
            clamp_h = HW'(MAX_HEIGHT);
        else
            clamp_h = HW'(v);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        h_ext     = RW'(h_reg);
        h_plus1   = h_ext + RW'(1);
        real_row  = (vrow_reg < h_ext);
        // one-row frame: the dilated row must be built before any flush beat can emit
        silent    = !real_row && (vrow_reg < RW'(2));
        in_ready  = push_ready && !silent;
        in_fire   = in_valid && in_ready;
        last_col  = (vcol_reg == AW'(w_reg - WW'(1)));
        frame_end = (vrow_reg == h_plus1) && last_col;

        if (silent)
            push_valid = 1'b1;
        else
            push_valid = in_fire && (!real_row || (opcode == bcc_pkg::OP_PIXEL));

        push_col              = vcol_reg;
        push_flags.parity     = vrow_reg[0];
        push_flags.row_ge1    = (vrow_reg != '0);
        push_flags.row_ge2    = (vrow_reg >= RW'(2));
        push_flags.row_ge3    = (vrow_reg >= RW'(3));
        push_flags.below_out  = (vrow_reg >= h_plus1);
        push_flags.first_col  = (vcol_reg == '0);
        push_flags.last_col   = last_col;
        push_flags.fg         = real_row && (pixel_value == bcc_pkg::PIX_ON);
        push_flags.frame_last = frame_end;
    end

    assign push_fire = push_valid && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= W_RESET;
            h_reg    <= H_RESET;
            vrow_reg <= '0;
            vcol_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                bcc_pkg::CFG_IMAGE_WIDTH:
                begin
                    w_reg    <= clamp_w(cfg_data);
                    vrow_reg <= '0;
                    vcol_reg <= '0;
                end
                bcc_pkg::CFG_IMAGE_HEIGHT:
                begin
                    h_reg    <= clamp_h(cfg_data);
                    vrow_reg <= '0;
                    vcol_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (push_fire)
        begin
            if (frame_end)
            begin
                vrow_reg <= '0;
                vcol_reg <= '0;
            end
            else if (last_col)
            begin
                vrow_reg <= vrow_reg + RW'(1);
                vcol_reg <= '0;
            end
            else
            begin
                vcol_reg <= vcol_reg + AW'(1);
            end
        end
    end

endmodule

// ----- rtl/bcc_back.sv -----
module bcc_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
    input  bcc_pkg::step_flags_t         q_flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   closed_pixel,
    output logic                         frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WD = bcc_pkg::WORD_W;

    // issue stage
    logic          s1_fire;
    logic [AW-1:0] col_next;

    // compute stage
    logic                 s2_valid_reg;
    logic [AW-1:0]        s2_col_reg;
    bcc_pkg::step_flags_t s2_flags_reg;
    logic                 s2_byp_a_reg;
    logic                 s2_byp_b_reg;
    logic [WD-1:0]        s2_byp_word_reg;
    logic                 s2_fire;
    logic                 s2_take;
    logic                 out_free;

    logic prev_in_reg;
    logic prev_dil_reg;

    logic       out_valid_reg;
    logic [7:0] closed_pixel_reg;
    logic       frame_last_reg;

    logic [WD-1:0] ram_a;
    logic [WD-1:0] ram_b;
    logic [WD-1:0] word_a;
    logic [WD-1:0] word_b;
    logic [WD-1:0] new_word;
    logic          p;
    logic          in_m1;
    logic          in_m2;
    logic          in_m1_nx;
    logic          dil_m2;
    logic          dil_m3;
    logic          dil_m2_nx;
    logic          d;
    logic          d_ero;
    logic          o;

    bcc_ram #(
        .WIDTH (WD),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (s2_fire),
        .waddr   (s2_col_reg),
        .wdata   (new_word),
        .re      (s1_fire),
        .raddr_a (q_col),
        .raddr_b (col_next),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s2_fire  = s2_valid_reg && (!s2_flags_reg.row_ge2 || out_free);
    assign s2_take  = !s2_valid_reg || s2_fire;
    assign q_ready  = s2_take;
    assign s1_fire  = q_valid && s2_take;
    assign col_next = q_col + AW'(1);

    always_comb
    begin
        word_a = s2_byp_a_reg ? s2_byp_word_reg : ram_a;
        word_b = s2_byp_b_reg ? s2_byp_word_reg : ram_b;
        p      = s2_flags_reg.parity;

        in_m1     = word_a[{bcc_pkg::IN_SLOT, ~p}];
        in_m2     = word_a[{bcc_pkg::IN_SLOT, p}];
        dil_m2    = word_a[{bcc_pkg::DIL_SLOT, p}];
        dil_m3    = word_a[{bcc_pkg::DIL_SLOT, ~p}];
        in_m1_nx  = word_b[{bcc_pkg::IN_SLOT, ~p}];
        dil_m2_nx = word_b[{bcc_pkg::DIL_SLOT, p}];

        // dilate the row above the entering pixel
        d = in_m1 | (s2_flags_reg.row_ge2 & in_m2) | s2_flags_reg.fg
            | (!s2_flags_reg.first_col & prev_in_reg)
            | (!s2_flags_reg.last_col & in_m1_nx);
        // a dilated row below the frame does not take part in the erosion
        d_ero = s2_flags_reg.below_out | d;
        o = d_ero & dil_m2
            & (!s2_flags_reg.row_ge3 | dil_m3)
            & (s2_flags_reg.first_col | prev_dil_reg)
            & (s2_flags_reg.last_col | dil_m2_nx);

        new_word = word_a;
        new_word[{bcc_pkg::IN_SLOT, p}] = s2_flags_reg.fg;
        if (s2_flags_reg.row_ge1)
        begin
            new_word[{bcc_pkg::DIL_SLOT, ~p}] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
                s2_valid_reg <= 1'b1;
            else if (s2_fire)
                s2_valid_reg <= 1'b0;

            if (s2_fire && s2_flags_reg.row_ge2)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_col_reg      <= q_col;
            s2_flags_reg    <= q_flags;
            // forward a write that lands in the same cycle as the read
            s2_byp_a_reg    <= s2_fire && (s2_col_reg == q_col);
            s2_byp_b_reg    <= s2_fire && (s2_col_reg == col_next);
            s2_byp_word_reg <= new_word;
        end
        if (s2_fire)
        begin
            prev_in_reg  <= in_m1;
            prev_dil_reg <= dil_m2;
        end
        if (s2_fire && s2_flags_reg.row_ge2)
        begin
            closed_pixel_reg <= o ? bcc_pkg::PIX_ON : bcc_pkg::PIX_OFF;
            frame_last_reg   <= s2_flags_reg.frame_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign closed_pixel = closed_pixel_reg;
    assign frame_last   = frame_last_reg;

endmodule
